[hw/rtl/dwc_pkg.sv]
package dwc_pkg;

  // Data formats
  localparam int SampleW  = 16;
  localparam int AccBits  = 24;
  localparam int AccInt   = 7;
  localparam int AccFrac  = AccBits - AccInt;
  localparam int ProdW    = 2 * SampleW;
  localparam int CountW   = 7;
  localparam int DimW     = 8;
  localparam int DimLimit = 128;
  localparam int DimMin   = 3;
  localparam int ReluTop  = 6;
  localparam int KSize    = 3;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = KSize * SampleW;

  // Parameter defaults
  localparam int DefMaxWidth    = 128;
  localparam int DefFeatureFrac = 10;
  localparam int DefWeightFrac  = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeightTop   = 3'd0,
    CfgWeightMid   = 3'd1,
    CfgWeightBot   = 3'd2,
    CfgBias        = 3'd3,
    CfgClampEnable = 3'd4,
    CfgPlaneWidth  = 3'd5,
    CfgPlaneHeight = 3'd6
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0] count_t;

  // 3x3 window: [kernel row][kernel column], column 0 is the oldest
  typedef sample_t [KSize-1:0][KSize-1:0] window_t;

  // Per-pixel control traveling with the window
  typedef struct packed {
    logic   emit;
    count_t row;
    count_t col;
    logic   last;
  } tag_t;

endpackage

[hw/rtl/dwc_if.sv]
interface dwc_pixel_if;
  logic             valid;
  logic             ready;
  dwc_pkg::sample_t pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface dwc_result_if;
  logic             valid;
  logic             ready;
  dwc_pkg::sample_t value;
  dwc_pkg::count_t  row;
  dwc_pkg::count_t  col;
  logic             last;

  modport source(output valid, output value, output row, output col, output last,
                 input ready);
  modport sink(input valid, input value, input row, input col, input last,
               output ready);
endinterface

[hw/rtl/depthwise_conv3x3_relu6_top.sv]
// Channel   Dir  Payload                         Handshake
// pixel_i   in   pixel (16, signed)              valid / ready
// result_o  out  value (16, s), row, col, last   valid / ready
// cfg       in   cfg_idx_i, cfg_data_i (48)      cfg_we_i, no wait
//
// One pixel per cycle; a stall on result_o holds the whole pipeline. A
// result is presented on result_o once its pixel has passed the line-store
// read, window, product, pair-sum, accumulator and output registers. The
// line store is one memory with a registered read, read when a pixel is
// taken and written back at the next edge that advances the pipeline.
// After reset the line store is swept to zero with pixel_i.ready low.
module depthwise_conv3x3_relu6_top #(
  parameter int MAX_WIDTH    = dwc_pkg::DefMaxWidth,
  parameter int FEATURE_FRAC = dwc_pkg::DefFeatureFrac,
  parameter int WEIGHT_FRAC  = dwc_pkg::DefWeightFrac
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dwc_pkg::CfgDataW-1:0] cfg_data_i,
  dwc_pixel_if.sink                    pixel_i,
  dwc_result_if.source                 result_o
);

  logic [dwc_pkg::CfgDataW-1:0] weight_top_q, weight_mid_q, weight_bot_q;
  dwc_pkg::sample_t             bias_q;
  logic                         clamp_en_q;
  logic [dwc_pkg::DimW-1:0]     plane_width_q, plane_height_q;

  dwc_pkg::window_t window;
  dwc_pkg::tag_t    tag;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_top_q   <= '0;
      weight_mid_q   <= '0;
      weight_bot_q   <= '0;
      bias_q         <= '0;
      clamp_en_q     <= 1'b0;
      plane_width_q  <= 8'd84;
      plane_height_q <= 8'd44;
    end else if (cfg_we_i) begin
      unique case (dwc_pkg::cfg_idx_e'(cfg_idx_i))
        dwc_pkg::CfgWeightTop:   weight_top_q   <= cfg_data_i;
        dwc_pkg::CfgWeightMid:   weight_mid_q   <= cfg_data_i;
        dwc_pkg::CfgWeightBot:   weight_bot_q   <= cfg_data_i;
        dwc_pkg::CfgBias:        bias_q         <= cfg_data_i[dwc_pkg::SampleW-1:0];
        dwc_pkg::CfgClampEnable: clamp_en_q     <= cfg_data_i[0];
        dwc_pkg::CfgPlaneWidth:  plane_width_q  <= cfg_data_i[dwc_pkg::DimW-1:0];
        dwc_pkg::CfgPlaneHeight: plane_height_q <= cfg_data_i[dwc_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  dwc_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_i       (pixel_i),
    .advance_i     (advance),
    .plane_width_i (plane_width_q),
    .plane_height_i(plane_height_q),
    .window_o      (window),
    .tag_o         (tag)
  );

  dwc_mac #(
    .FEATURE_FRAC(FEATURE_FRAC),
    .WEIGHT_FRAC (WEIGHT_FRAC)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window),
    .tag_i       (tag),
    .weight_top_i(weight_top_q),
    .weight_mid_i(weight_mid_q),
    .weight_bot_i(weight_bot_q),
    .bias_i      (bias_q),
    .clamp_en_i  (clamp_en_q),
    .advance_o   (advance),
    .result_o    (result_o)
  );

endmodule

[hw/rtl/dwc_ram.sv]
module dwc_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dwc_line_buf.sv]
module dwc_line_buf #(
  parameter int MAX_WIDTH = dwc_pkg::DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dwc_pixel_if.sink                    pixel_i,
  input  logic                         advance_i,
  input  logic [dwc_pkg::DimW-1:0]     plane_width_i,
  input  logic [dwc_pkg::DimW-1:0]     plane_height_i,
  output dwc_pkg::window_t             window_o,
  output dwc_pkg::tag_t                tag_o
);

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int WordW    = 2 * dwc_pkg::SampleW;
  localparam int WMax     = (MAX_WIDTH < dwc_pkg::DimLimit) ? MAX_WIDTH : dwc_pkg::DimLimit;
  localparam logic [AW-1:0] LastAddr = AW'(MAX_WIDTH - 1);
  localparam logic [dwc_pkg::DimW-1:0] DimMinV = dwc_pkg::DimW'(dwc_pkg::DimMin);
  localparam logic [dwc_pkg::DimW-1:0] WMaxV   = dwc_pkg::DimW'(WMax);
  localparam logic [dwc_pkg::DimW-1:0] HMaxV   = dwc_pkg::DimW'(dwc_pkg::DimLimit);

  // Clearing pass
  logic            clr_busy_q, clr_busy_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;

  // Raster counters
  dwc_pkg::count_t row_q, row_d, col_q, col_d;

  // Stage 1: pixel waiting for its line-store read
  logic            s1_valid_q;
  dwc_pkg::sample_t s1_pix_q;
  logic [AW-1:0]   s1_addr_q;
  dwc_pkg::tag_t   s1_tag_q;

  // Stage 2: window
  dwc_pkg::window_t win_q;
  dwc_pkg::tag_t    tag_q, tag_d;

  logic                     accept;
  logic [dwc_pkg::DimW-1:0] w_eff, h_eff;
  logic                     col_end, row_end;
  logic [AW-1:0]            rd_addr;
  dwc_pkg::tag_t            new_tag;
  logic [WordW-1:0]         rd_word;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WordW-1:0]         ram_wdata;
  logic                     s1_move;

  assign pixel_i.ready = ~clr_busy_q & advance_i;
  assign accept        = pixel_i.valid & pixel_i.ready;
  assign s1_move       = s1_valid_q & advance_i;

  // Saturate the plane dimensions
  always_comb begin
    if (plane_width_i < DimMinV) begin
      w_eff = DimMinV;
    end else if (plane_width_i > WMaxV) begin
      w_eff = WMaxV;
    end else begin
      w_eff = plane_width_i;
    end
    if (plane_height_i < DimMinV) begin
      h_eff = DimMinV;
    end else if (plane_height_i > HMaxV) begin
      h_eff = HMaxV;
    end else begin
      h_eff = plane_height_i;
    end
  end

  assign col_end = {1'b0, col_q} >= (w_eff - 8'd1);
  assign row_end = {1'b0, row_q} >= (h_eff - 8'd1);

  // Line-store address of the current column
  assign rd_addr = (32'(col_q) < MAX_WIDTH) ? AW'(col_q) : LastAddr;

  // Output position and flags of the current pixel
  always_comb begin
    new_tag.emit = (row_q >= 7'd2) && (col_q >= 7'd2);
    new_tag.row  = row_q - 7'd1;
    new_tag.col  = col_q - 7'd1;
    new_tag.last = row_end & col_end;
  end

  // Pass the tag on, live only for a pixel that moves into the window
  always_comb begin
    tag_d      = s1_tag_q;
    tag_d.emit = s1_valid_q & s1_tag_q.emit;
  end

  // Advance the raster counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 7'd1;
      end else begin
        col_d = col_q + 7'd1;
      end
    end
  end

  // Sweep the line store to zero after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // Write back: upper line moves down, new pixel becomes the upper line
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_move;
      ram_waddr = s1_addr_q;
      ram_wdata = {s1_pix_q, rd_word[WordW-1:dwc_pkg::SampleW]};
    end
  end

  dwc_ram #(
    .Width(WordW),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_word)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_tag_q   <= '0;
      tag_q      <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      row_q      <= row_d;
      col_q      <= col_d;
      if (advance_i) begin
        s1_valid_q <= accept;
        tag_q      <= tag_d;
      end
      if (accept) begin
        s1_tag_q <= new_tag;
      end
    end
  end

  // Payload: hold the pixel, shift the window on each pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i.pixel;
      s1_addr_q <= rd_addr;
    end
    if (s1_move) begin
      for (int r = 0; r < dwc_pkg::KSize; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_word[dwc_pkg::SampleW-1:0];
      win_q[1][2] <= rd_word[WordW-1:dwc_pkg::SampleW];
      win_q[2][2] <= s1_pix_q;
    end
  end

  assign window_o = win_q;
  assign tag_o    = tag_q;

endmodule

[hw/rtl/dwc_mac.sv]
module dwc_mac #(
  parameter int FEATURE_FRAC = dwc_pkg::DefFeatureFrac,
  parameter int WEIGHT_FRAC  = dwc_pkg::DefWeightFrac
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dwc_pkg::window_t            window_i,
  input  dwc_pkg::tag_t               tag_i,
  input  logic [dwc_pkg::CfgDataW-1:0] weight_top_i,
  input  logic [dwc_pkg::CfgDataW-1:0] weight_mid_i,
  input  logic [dwc_pkg::CfgDataW-1:0] weight_bot_i,
  input  dwc_pkg::sample_t            bias_i,
  input  logic                        clamp_en_i,
  output logic                        advance_o,
  dwc_result_if.source                result_o
);

  localparam int K       = dwc_pkg::KSize;
  localparam int SW      = dwc_pkg::SampleW;
  localparam int PW      = dwc_pkg::ProdW;
  localparam int AB      = dwc_pkg::AccBits;
  localparam int NPairs  = 5;
  localparam int ExtW    = 48;
  localparam int ProdFrac = FEATURE_FRAC + WEIGHT_FRAC;
  localparam int PairShR = (ProdFrac >= dwc_pkg::AccFrac) ? ProdFrac - dwc_pkg::AccFrac : 0;
  localparam int PairShL = (ProdFrac < dwc_pkg::AccFrac) ? dwc_pkg::AccFrac - ProdFrac : 0;
  localparam int BiasShR = (WEIGHT_FRAC >= FEATURE_FRAC) ? WEIGHT_FRAC - FEATURE_FRAC : 0;
  localparam int BiasShL = (FEATURE_FRAC > WEIGHT_FRAC) ? FEATURE_FRAC - WEIGHT_FRAC : 0;
  localparam int AccShR  = dwc_pkg::AccFrac - FEATURE_FRAC;
  localparam int TopInt  = dwc_pkg::ReluTop << FEATURE_FRAC;

  logic [dwc_pkg::CfgDataW-1:0] wrow [K];

  // Products stage
  logic signed [PW-1:0] prod_q [K][K];
  dwc_pkg::tag_t        m_tag_q;
  // Pair-sum stage
  logic signed [AB-1:0] pair_q [NPairs];
  logic signed [AB-1:0] pair_d [NPairs];
  dwc_pkg::tag_t        p_tag_q;
  // Accumulator stage
  logic signed [AB-1:0] acc_q, acc_d;
  dwc_pkg::tag_t        a_tag_q;
  // Output register
  logic                 res_valid_q;
  dwc_pkg::sample_t     res_value_q, res_value_d;
  dwc_pkg::count_t      res_row_q, res_col_q;
  logic                 res_last_q;

  logic signed [SW-1:0] bias_f;
  logic signed [AB-1:0] acc_sh;
  logic signed [SW-1:0] vsum;

  assign wrow[0] = weight_top_i;
  assign wrow[1] = weight_mid_i;
  assign wrow[2] = weight_bot_i;

  assign advance_o = ~res_valid_q | result_o.ready;

  // Cut a sum of two products to the accumulator format (floor, wrap)
  function automatic logic signed [AB-1:0] pair_cut(logic signed [PW-1:0] a,
                                                    logic signed [PW-1:0] b);
    logic signed [PW:0]     s;
    logic signed [ExtW-1:0] e;
    s = (PW+1)'(a) + (PW+1)'(b);
    e = ExtW'(s);
    e = (e <<< PairShL) >>> PairShR;
    return e[AB-1:0];
  endfunction

  // Pair the nine products in row-major order
  always_comb begin
    pair_d[0] = pair_cut(prod_q[0][0], prod_q[0][1]);
    pair_d[1] = pair_cut(prod_q[0][2], prod_q[1][0]);
    pair_d[2] = pair_cut(prod_q[1][1], prod_q[1][2]);
    pair_d[3] = pair_cut(prod_q[2][0], prod_q[2][1]);
    pair_d[4] = pair_cut(prod_q[2][2], '0);
  end

  assign acc_d = pair_q[0] + pair_q[1] + pair_q[2] + pair_q[3] + pair_q[4];

  // Bias in feature format, then add to the scaled-down accumulator
  always_comb begin
    logic signed [31:0] bw;
    bw     = (32'(bias_i) <<< BiasShL) >>> BiasShR;
    bias_f = bw[SW-1:0];
    acc_sh = acc_q >>> AccShR;
    vsum   = bias_f + acc_sh[SW-1:0];
  end

  // Optional ReLU6 clamp
  always_comb begin
    res_value_d = vsum;
    if (clamp_en_i) begin
      if (vsum < 0) begin
        res_value_d = '0;
      end else if (32'(vsum) > TopInt) begin
        res_value_d = SW'(TopInt);
      end
    end
  end

  // Control of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tag_q     <= '0;
      p_tag_q     <= '0;
      a_tag_q     <= '0;
      res_valid_q <= 1'b0;
    end else if (advance_o) begin
      m_tag_q     <= tag_i;
      p_tag_q     <= m_tag_q;
      a_tag_q     <= p_tag_q;
      res_valid_q <= a_tag_q.emit;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          prod_q[r][c] <= $signed(wrow[r][c*SW +: SW]) * $signed(window_i[r][c]);
        end
      end
      for (int i = 0; i < NPairs; i++) begin
        pair_q[i] <= pair_d[i];
      end
      acc_q       <= acc_d;
      res_value_q <= res_value_d;
      res_row_q   <= a_tag_q.row;
      res_col_q   <= a_tag_q.col;
      res_last_q  <= a_tag_q.last;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.value = res_value_q;
  assign result_o.row   = res_row_q;
  assign result_o.col   = res_col_q;
  assign result_o.last  = res_last_q;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import dwc_pkg::*;

  localparam int MaxWidth    = DefMaxWidth;
  localparam int FeatureFrac = DefFeatureFrac;
  localparam int WeightFrac  = DefWeightFrac;
  localparam int ProdFrac    = FeatureFrac + WeightFrac;
  localparam int WidthCap    = (MaxWidth < DimLimit) ? MaxWidth : DimLimit;
  localparam int NumTaps     = KSize * KSize;
  localparam int NumRegs     = 7;
  localparam int NumDirected = 31;
  localparam int DrainCycles = 10;      // extra wait after the last expected output leaves
  localparam int RandomItems = 850;
  localparam int CalmAfter   = 700;
  localparam int SqueezeAt   = 300;
  localparam int SqueezeLen  = 60;
  localparam int CycleLimit  = 100000;

  typedef struct packed {
    sample_t value;
    count_t  row;
    count_t  col;
    logic    last;
  } conv_out_t;

  typedef enum logic {StepPixel, StepWrite} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    sample_t             pixel;
    logic                fixed;   // value is known without the predictor
    sample_t             value;
  } dir_step_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  dwc_pixel_if  pix_ch ();
  dwc_result_if res_ch ();

  // Predictor state: register shadows, line rows, window and raster position
  logic [CfgDataW-1:0] reg_shadow [NumRegs];
  sample_t             line_rows [2][MaxWidth];
  sample_t             win [KSize][KSize];
  int unsigned         row_cnt;
  int unsigned         col_cnt;

  conv_out_t   pending_outputs [$];
  int unsigned error_count = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  bit          squeeze_req = 1'b0;

  dir_step_t directed_steps [NumDirected];

  depthwise_conv3x3_relu6_top #(
    .MAX_WIDTH   (MaxWidth),
    .FEATURE_FRAC(FeatureFrac),
    .WEIGHT_FRAC (WeightFrac)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pixel_i   (pix_ch),
    .result_o  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_error(input string what);
    $display("%0t ERROR %s", $realtime, what);
    error_count++;
  endtask

  // Sign-wrap a value to the given number of bits
  function automatic longint wrap_to(longint v, int bits);
    longint t;
    t = v <<< (64 - bits);
    return t >>> (64 - bits);
  endfunction

  // Move between fraction widths, flooring when bits are dropped
  function automatic longint requantize(longint v, int from_frac, int to_frac);
    if (from_frac >= to_frac) return v >>> (from_frac - to_frac);
    return v <<< (to_frac - from_frac);
  endfunction

  function automatic int unsigned clip_dim(logic [DimW-1:0] v, int unsigned hi);
    if (v < DimMin) return DimMin;
    if (v > hi) return hi;
    return v;
  endfunction

  // Weight times window sample for tap k, taps in row-major order
  function automatic longint tap_product(int k);
    sample_t wt;
    wt = reg_shadow[int'(CfgWeightTop) + k / KSize][SampleW * (k % KSize) +: SampleW];
    return longint'(wt) * longint'(win[k / KSize][k % KSize]);
  endfunction

  // Take one pixel into the window; return 1 with the output it produces
  function automatic bit convolve_pixel(input sample_t px, output conv_out_t res);
    int unsigned w, h, r, c, ci;
    bit          at_end;
    longint      acc, bias_f, v;
    w      = clip_dim(reg_shadow[CfgPlaneWidth][DimW-1:0], WidthCap);
    h      = clip_dim(reg_shadow[CfgPlaneHeight][DimW-1:0], DimLimit);
    r      = row_cnt;
    c      = col_cnt;
    ci     = (c < MaxWidth) ? c : MaxWidth - 1;
    at_end = (r >= h - 1) && (c >= w - 1);
    res    = '0;

    // shift the window left and bring in the new column
    for (int k = 0; k < KSize; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_rows[0][ci];
    win[1][2] = line_rows[1][ci];
    win[2][2] = px;
    line_rows[0][ci] = line_rows[1][ci];
    line_rows[1][ci] = px;

    // advance the raster position, wrapping from at or past the last one
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : (r + 1) % (1 << CountW);
    end else begin
      col_cnt = (c + 1) % (1 << CountW);
    end

    if (r < 2 || c < 2) return 1'b0;

    // pairwise products, each cut to the accumulator format
    acc = 0;
    for (int k = 0; k < NumTaps; k += 2) begin
      longint pair_s;
      pair_s = tap_product(k);
      if (k + 1 < NumTaps) pair_s += tap_product(k + 1);
      acc += wrap_to(requantize(pair_s, ProdFrac, AccFrac), AccBits);
    end
    acc = wrap_to(acc, AccBits);

    bias_f = wrap_to(requantize(longint'(sample_t'(reg_shadow[CfgBias][SampleW-1:0])),
                                WeightFrac, FeatureFrac), SampleW);
    v = requantize(bias_f, FeatureFrac, AccFrac) + acc;
    v = wrap_to(requantize(v, AccFrac, FeatureFrac), SampleW);
    if (reg_shadow[CfgClampEnable][0]) begin
      if (v > (longint'(ReluTop) <<< FeatureFrac)) v = longint'(ReluTop) <<< FeatureFrac;
      if (v < 0) v = 0;
    end

    res.value = v[SampleW-1:0];
    res.row   = count_t'(r - 1);
    res.col   = count_t'(c - 1);
    res.last  = at_end;
    return 1'b1;
  endfunction

  function automatic sample_t random_word();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2, 3:    return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(11, 255);
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  // Offer one pixel, hold it until taken, then log what it should produce
  task automatic send_pixel(input sample_t px, input bit fixed, input sample_t fixed_val);
    conv_out_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    if (convolve_pixel(px, res)) begin
      if (fixed) res.value = fixed_val;
      pending_outputs.push_back(res);
    end
    @(negedge clk);
  endtask

  // Drop valid, let every outstanding output drain, then let the pipe settle
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // Drive one register write; the caller lowers the enable after the group
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    reg_shadow[idx] = data;
    @(negedge clk);
  endtask

  // Output ready: random short stalls, and one long hold on request
  initial begin : result_pacer
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req  = 1'b0;
        stall_left   = SqueezeLen - 1;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    conv_out_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_outputs.size() == 0) begin
        note_error($sformatf("unexpected output (%0d,%0d) value %h",
                             res_ch.row, res_ch.col, res_ch.value));
      end else begin
        want = pending_outputs.pop_front();
        if (res_ch.value !== want.value)
          note_error($sformatf("value at (%0d,%0d): got %h want %h",
                               want.row, want.col, res_ch.value, want.value));
        if (res_ch.row !== want.row)
          note_error($sformatf("row: got %0d want %0d", res_ch.row, want.row));
        if (res_ch.col !== want.col)
          note_error($sformatf("col: got %0d want %0d", res_ch.col, want.col));
        if (res_ch.last !== want.last)
          note_error($sformatf("last at (%0d,%0d): got %b want %b",
                               want.row, want.col, res_ch.last, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d outputs outstanding",
               cycles, pending_outputs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned         random_sent;
    int unsigned         count;
    int unsigned         phase;
    logic [NumRegs-1:0]  mask;
    logic [CfgDataW-1:0] next_regs [NumRegs];

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgWeightTop;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;

    // hold the reset state of the predictor
    foreach (reg_shadow[k]) reg_shadow[k] = '0;
    reg_shadow[CfgPlaneWidth]  = 84;
    reg_shadow[CfgPlaneHeight] = 44;
    foreach (line_rows[a, b]) line_rows[a][b] = '0;
    foreach (win[a, b]) win[a][b] = '0;
    row_cnt = 0;
    col_cnt = 0;

    directed_steps = '{
      // reset weights and bias are zero; out-of-range dims saturate to 3x3
      '{StepWrite, CfgPlaneWidth,  48'd2, 16'h0000, 1'b0, 16'h0000},
      '{StepWrite, CfgPlaneHeight, 48'd0, 16'h0000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h0000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'hFFFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h5555, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'hAAAA, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h0001, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFE, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8001, 1'b1, 16'h0000},
      // unit weight on the center tap with ReLU6: the center pixel passes, clamped
      '{StepWrite, CfgWeightMid,   48'h0000_4000_0000, 16'h0000, 1'b0, 16'h0000},
      '{StepWrite, CfgClampEnable, 48'd1, 16'h0000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h2000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b1, 16'h1800},
      // most negative center pixel clamps to zero
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h8000, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b0, 16'h0000},
      '{StepPixel, CfgWeightTop, 48'd0, 16'h7FFF, 1'b1, 16'h0000}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      if (directed_steps[i].kind == StepWrite) begin
        if (i == 0 || directed_steps[i-1].kind != StepWrite) wait_idle();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        if (i > 0 && directed_steps[i-1].kind == StepWrite) cfg_we <= 1'b0;
        send_pixel(directed_steps[i].pixel, directed_steps[i].fixed,
                   directed_steps[i].value);
      end
    end

    // random phases: new settings between drained runs of pixels
    random_sent = 0;
    phase       = 0;
    while (random_sent < RandomItems) begin
      wait_idle();
      idle_on = (random_sent < CalmAfter) && ($urandom_range(0, 3) != 0);

      for (int k = 0; k < KSize; k++)
        for (int j = 0; j < KSize; j++)
          next_regs[int'(CfgWeightTop) + k][SampleW*j +: SampleW] = random_word();
      next_regs[CfgBias]        = {{(CfgDataW-SampleW){1'b0}}, random_word()};
      next_regs[CfgClampEnable] = $urandom_range(0, 1);
      next_regs[CfgPlaneWidth]  = random_dim();
      next_regs[CfgPlaneHeight] = random_dim();
      mask  = $urandom_range(1, (1 << NumRegs) - 1);
      count = $urandom_range(5, 60);
      if (phase == 0) begin
        // widest plane, three rows, run to its end
        next_regs[CfgPlaneWidth]  = $urandom_range(0, 1) ? 48'd128 : 48'd255;
        next_regs[CfgPlaneHeight] = KSize;
        mask  = '1;
        count = KSize * WidthCap;
      end else if (phase == 1) begin
        // tallest plane, left part way through
        next_regs[CfgPlaneWidth]  = KSize;
        next_regs[CfgPlaneHeight] = DimLimit;
        mask  = '1;
        count = $urandom_range(90, 120);
      end

      for (int k = 0; k < NumRegs; k++)
        if (mask[k]) write_reg(cfg_idx_e'(k), next_regs[k]);
      cfg_we <= 1'b0;

      repeat (count) begin
        if (random_sent == SqueezeAt) squeeze_req = 1'b1;
        if (random_sent >= CalmAfter) idle_on = 1'b0;
        send_pixel(random_word(), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
